FILE: hw/rtl/gli_pkg.sv
// Shared types, codes and letter decoding for the G-code line interpreter.
package gli_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LETTER,
		PH_NUMBER,
		PH_COMMENT,
		PH_SKIP
	} phase_t;

	typedef enum logic [1:0] {
		E_IDLE,
		E_FEED,
		E_SCAN,
		E_LOAD
	} emit_state_t;

	localparam int SLOT_W = 5;
	localparam int NSLOT  = 18;
	localparam int RAM_DEPTH = 15;
	localparam int RAM_AW = 4;
	localparam int CODE_W = 16;
	localparam int ITEM_COUNT = 14;
	localparam int IDX_W = 4;

	localparam logic [SLOT_W-1:0] SL_F = 5'd9;
	localparam logic [SLOT_W-1:0] SL_S = 5'd10;
	localparam logic [SLOT_W-1:0] SL_P = 5'd11;
	localparam logic [SLOT_W-1:0] SL_I = 5'd12;
	localparam logic [SLOT_W-1:0] SL_J = 5'd13;
	localparam logic [SLOT_W-1:0] SL_K = 5'd14;
	localparam logic [SLOT_W-1:0] SL_G = 5'd15;
	localparam logic [SLOT_W-1:0] SL_M = 5'd16;
	localparam logic [SLOT_W-1:0] SL_T = 5'd17;

	// item positions of one line's result list
	localparam logic [IDX_W-1:0] IT_HEAD = 4'd0;
	localparam logic [IDX_W-1:0] IT_AX_LAST = 4'd9;
	localparam logic [IDX_W-1:0] IT_CTR = 4'd10;
	localparam logic [IDX_W-1:0] IT_CTR_LAST = 4'd12;
	localparam logic [IDX_W-1:0] IT_M = 4'd13;
	localparam logic [IDX_W-1:0] IT_END = 4'd14;

	localparam logic [3:0] CK_TRAVERSE = 4'd0;
	localparam logic [3:0] CK_FEED     = 4'd1;
	localparam logic [3:0] CK_ARC      = 4'd2;
	localparam logic [3:0] CK_DWELL    = 4'd3;
	localparam logic [3:0] CK_COORD    = 4'd4;
	localparam logic [3:0] CK_TOOLOFS  = 4'd5;
	localparam logic [3:0] CK_HOME     = 4'd6;
	localparam logic [3:0] CK_STOP     = 4'd7;
	localparam logic [3:0] CK_OSTOP    = 4'd8;
	localparam logic [3:0] CK_END      = 4'd9;
	localparam logic [3:0] CK_SPIN_ON  = 4'd10;
	localparam logic [3:0] CK_SPIN_OFF = 4'd11;
	localparam logic [3:0] CK_TOOLCHG  = 4'd12;
	localparam logic [3:0] CK_MIST_ON  = 4'd13;
	localparam logic [3:0] CK_MIST_OFF = 4'd14;
	localparam logic [3:0] CK_FLOOD    = 4'd15;

	localparam logic [1:0] EK_HEADER = 2'd0;
	localparam logic [1:0] EK_AXIS   = 2'd1;
	localparam logic [1:0] EK_CENTRE = 2'd2;

	localparam logic [1:0] PL_XY = 2'd0;

	typedef struct packed {
		logic                     valid;
		logic [NSLOT-1:0]         present;
		logic signed [CODE_W-1:0] g;
		logic signed [CODE_W-1:0] m;
		logic signed [CODE_W-1:0] t;
	} line_t;

	// Upper-case letter to word slot; MSB flags a known letter. Axis slots are 0..8.
	function automatic logic [SLOT_W:0] letter_slot(input logic [7:0] c);
		logic [SLOT_W:0] r;
		r = '0;
		case (c)
			"X": r = {1'b1, 5'd0};
			"Y": r = {1'b1, 5'd1};
			"Z": r = {1'b1, 5'd2};
			"A": r = {1'b1, 5'd3};
			"B": r = {1'b1, 5'd4};
			"C": r = {1'b1, 5'd5};
			"U": r = {1'b1, 5'd6};
			"V": r = {1'b1, 5'd7};
			"W": r = {1'b1, 5'd8};
			"F": r = {1'b1, SL_F};
			"S": r = {1'b1, SL_S};
			"P": r = {1'b1, SL_P};
			"I": r = {1'b1, SL_I};
			"J": r = {1'b1, SL_J};
			"K": r = {1'b1, SL_K};
			"G": r = {1'b1, SL_G};
			"M": r = {1'b1, SL_M};
			"T": r = {1'b1, SL_T};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/gcode_line_interpreter.sv
// Top level of the G-code line interpreter: request streams, scanner, value store, sequencer.
// The block reads one ASCII character per accepted request and turns each program line
// into canonical motion and machine commands. A character is taken every cycle while a
// line is being read. The request that carries tlast closes the line: input then stalls
// while the last word is finished and written into the word value store and the
// sequencer issues the read of the kept feed, and then while the line-end sequencer runs.
// The sequencer first takes the kept feed; then, for each result, it issues one store
// read and then loads the output register, waiting while that register is full; it skips
// every list position that produces nothing and ends with a closing step. The store
// read port is what paces the sequencer. Results leave through a one-deep output register
// that holds while m_tready is low; the next line may start while the final result of a
// line still waits.
module gcode_line_interpreter #(
	parameter int AXIS_COUNT  = 9,
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_DIGITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // ch[7:0]
	input  logic        s_tlast,   // line_end
	output logic        m_tvalid,
	input  logic        m_tready,
	// cmd_kind[3:0], axis_mask[12:4], arg_value[44:13], arc_ccw[45], elem_index[49:46],
	// elem_value[81:50], metric_mode[82], absolute_mode[83], plane_sel[85:84], zero pad
	output logic [87:0] m_tdata,
	output logic [1:0]  m_tuser,   // elem_kind[1:0]
	output logic        m_tlast    // last
);

	logic acc, blocked, busy;
	logic wr_en, rd_en;
	logic [gli_pkg::RAM_AW-1:0] wr_addr, rd_addr;
	logic signed [VALUE_WIDTH-1:0] wr_data, rd_data;
	gli_pkg::line_t line;

	// hold input while a line is closing or being emitted
	assign s_tready = !blocked && !busy;
	assign acc = s_tvalid && s_tready;

	gli_lexer #(
		.AXIS_COUNT(AXIS_COUNT),
		.VALUE_WIDTH(VALUE_WIDTH),
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_lexer (
		.clk(clk), .arst_n(arst_n),
		.acc(acc), .ch(s_tdata), .line_end(s_tlast),
		.blocked(blocked),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.line(line)
	);

	gli_word_ram #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
	);

	gli_emitter #(
		.AXIS_COUNT(AXIS_COUNT),
		.VALUE_WIDTH(VALUE_WIDTH),
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_emit (
		.clk(clk), .arst_n(arst_n),
		.line(line), .busy(busy),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	// no store write may land while the sequencer reads the store
	a_no_write_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !wr_en) else $error("word store written during emission");

	// a closed line stops further requests on the next cycle
	a_stall_after_line: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tlast) |=> !s_tready) else $error("request taken after line end");

	// element results only follow motion headers
	a_elem_motion: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != gli_pkg::EK_HEADER) |-> (m_tdata[3:0] <= gli_pkg::CK_ARC))
		else $error("element result with a non-motion kind");

endmodule

FILE: hw/rtl/gli_word_ram.sv
// Word value store: one write port, one registered read port.
module gli_word_ram #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [gli_pkg::RAM_AW-1:0]     wr_addr,
	input  logic signed [VALUE_WIDTH-1:0]  wr_data,
	input  logic                           rd_en,
	input  logic [gli_pkg::RAM_AW-1:0]     rd_addr,
	output logic signed [VALUE_WIDTH-1:0]  rd_data
);

	logic signed [VALUE_WIDTH-1:0] mem [gli_pkg::RAM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: hw/rtl/gli_lexer.sv
// Character scanner and word finisher: builds present bits, code numbers and stored values.
module gli_lexer #(
	parameter int AXIS_COUNT  = 9,
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_DIGITS = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               acc,
	input  logic [7:0]                         ch,
	input  logic                               line_end,
	output logic                               blocked,
	output logic                               wr_en,
	output logic [gli_pkg::RAM_AW-1:0]         wr_addr,
	output logic signed [VALUE_WIDTH-1:0]      wr_data,
	output gli_pkg::line_t                     line
);

	function automatic longint unsigned pow10(input int n);
		longint unsigned p;
		p = 1;
		for (int i = 0; i < 6; i++) begin
			if (i < n) p = p * 10;
		end
		return p;
	endfunction

	localparam longint unsigned PW = pow10(FRAC_DIGITS);
	localparam longint unsigned HALF = 64'd1 << (VALUE_WIDTH - 1);
	localparam longint unsigned LIMQ_P = (HALF - 1) / PW;
	localparam longint unsigned LIMQ_N = HALF / PW;
	localparam longint unsigned CAP = ((LIMQ_N > 32768) ? LIMQ_N : 64'd32768) + 1;
	localparam int ACC_W = $clog2(CAP + 1);
	localparam int FRAC_W = $clog2(PW);
	localparam int CNT_W = $clog2(FRAC_DIGITS + 1);
	localparam int VW = VALUE_WIDTH;

	gli_pkg::phase_t phase_q, phase_n, ret_q, ret_n;
	logic [gli_pkg::SLOT_W-1:0] slot_q, slot_n;
	logic slot_ok_q, slot_ok_n, open_q, open_n, neg_q, neg_n, dot_q, dot_n, stop_q, stop_n;
	logic [ACC_W-1:0] acc_q, acc_n;
	logic [FRAC_W-1:0] frac_q, frac_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic pend_q, fin;

	logic fin_s1, line_s1, neg_s1;
	logic [gli_pkg::SLOT_W-1:0] slot_s1;
	logic [ACC_W-1:0] acc_s1;
	logic [FRAC_W-1:0] frac_s1;
	logic [CNT_W-1:0] cnt_s1;

	logic [gli_pkg::NSLOT-1:0] present_q, present_n;
	logic signed [gli_pkg::CODE_W-1:0] g_q, m_q, t_q, g_n, m_n, t_n, code;
	gli_pkg::line_t line_q;

	logic digit;
	logic [3:0] dval;
	logic [7:0] up;
	logic [gli_pkg::SLOT_W:0] ls;
	logic [ACC_W+3:0] acc_x;
	logic [FRAC_W+3:0] frac_x;
	logic [16:0] c17;
	logic [VW-1:0] lim, raw, mag, scale;
	logic over;

	assign digit = (ch >= "0") && (ch <= "9");
	assign dval = ch[3:0];
	assign up = ((ch >= "a") && (ch <= "z")) ? (ch - 8'd32) : ch;
	assign ls = gli_pkg::letter_slot(up);
	assign acc_x = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + (ACC_W + 4)'(dval);
	assign frac_x = {frac_q, 3'b000} + {2'b00, frac_q, 1'b0} + (FRAC_W + 4)'(dval);

	always_comb begin
		phase_n = phase_q; ret_n = ret_q; slot_n = slot_q; slot_ok_n = slot_ok_q;
		open_n = open_q; neg_n = neg_q; dot_n = dot_q; stop_n = stop_q;
		acc_n = acc_q; frac_n = frac_q; cnt_n = cnt_q;
		fin = 1'b0;
		if (acc) begin
			case (phase_q)
				gli_pkg::PH_SKIP: ;
				gli_pkg::PH_COMMENT: begin
					if (ch == ")") begin
						phase_n = ret_q;
					end else if (ch == ";" || ch == 8'd0) begin
						fin = 1'b1;
						phase_n = gli_pkg::PH_SKIP;
					end
				end
				default: begin
					if (ch == ";" || ch == 8'd0) begin
						fin = 1'b1;
						phase_n = gli_pkg::PH_SKIP;
					end else if (ch == "(") begin
						ret_n = phase_q;
						phase_n = gli_pkg::PH_COMMENT;
					end else if (phase_q == gli_pkg::PH_LETTER && (ch == "+" || ch == "-")) begin
						neg_n = (ch == "-");
						phase_n = gli_pkg::PH_NUMBER;
					end else if ((phase_q == gli_pkg::PH_LETTER || phase_q == gli_pkg::PH_NUMBER)
						&& (digit || ch == ".")) begin
						phase_n = gli_pkg::PH_NUMBER;
						if (!stop_q) begin
							if (ch == ".") begin
								if (dot_q) stop_n = 1'b1;
								else dot_n = 1'b1;
							end else if (!dot_q) begin
								acc_n = (acc_x > (ACC_W + 4)'(CAP)) ? ACC_W'(CAP) : acc_x[ACC_W-1:0];
							end else if (cnt_q < CNT_W'(FRAC_DIGITS)) begin
								frac_n = frac_x[FRAC_W-1:0];
								cnt_n = cnt_q + 1'b1;
							end
						end
					end else begin
						fin = 1'b1;
						phase_n = gli_pkg::PH_IDLE;
						if (!(ch == " " || (ch >= 8'd9 && ch <= 8'd13))) begin
							slot_n = ls[gli_pkg::SLOT_W-1:0];
							slot_ok_n = ls[gli_pkg::SLOT_W] &&
								(ls[gli_pkg::SLOT_W-1:0] >= 5'd9 ||
								 int'(ls[gli_pkg::SLOT_W-1:0]) < AXIS_COUNT);
							acc_n = '0; frac_n = '0; cnt_n = '0;
							neg_n = 1'b0; dot_n = 1'b0; stop_n = 1'b0;
							open_n = 1'b1;
							phase_n = gli_pkg::PH_LETTER;
						end
					end
				end
			endcase
			if (fin && !(phase_n == gli_pkg::PH_LETTER)) open_n = 1'b0;
		end
		if (pend_q) begin
			// close the last word, then start the next line clean
			fin = 1'b1;
			phase_n = gli_pkg::PH_IDLE;
			ret_n = gli_pkg::PH_IDLE;
			open_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gli_pkg::PH_IDLE;
			ret_q <= gli_pkg::PH_IDLE;
			open_q <= 1'b0;
			pend_q <= 1'b0;
			fin_s1 <= 1'b0;
			line_s1 <= 1'b0;
			present_q <= '0;
			g_q <= '0; m_q <= '0; t_q <= '0;
			line_q <= '0;
		end else begin
			phase_q <= phase_n;
			ret_q <= ret_n;
			open_q <= open_n;
			pend_q <= acc && line_end;
			fin_s1 <= fin && open_q && slot_ok_q;
			line_s1 <= pend_q;
			line_q.valid <= line_s1;
			line_q.present <= present_n;
			line_q.g <= g_n; line_q.m <= m_n; line_q.t <= t_n;
			if (line_s1) begin
				present_q <= '0;
				g_q <= '0; m_q <= '0; t_q <= '0;
			end else begin
				present_q <= present_n;
				g_q <= g_n; m_q <= m_n; t_q <= t_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_n; slot_ok_q <= slot_ok_n; neg_q <= neg_n;
		dot_q <= dot_n; stop_q <= stop_n;
		acc_q <= acc_n; frac_q <= frac_n; cnt_q <= cnt_n;
		if (fin) begin
			slot_s1 <= slot_q; neg_s1 <= neg_q; acc_s1 <= acc_q;
			frac_s1 <= frac_q; cnt_s1 <= cnt_q;
		end
	end

	// finish stage: scale, saturate, and file the word
	always_comb begin
		if (neg_s1) c17 = (acc_s1 > ACC_W'(32768)) ? 17'd32768 : 17'(acc_s1);
		else c17 = (acc_s1 > ACC_W'(32767)) ? 17'd32767 : 17'(acc_s1);
		code = neg_s1 ? gli_pkg::CODE_W'(-c17) : gli_pkg::CODE_W'(c17);
		scale = VW'(pow10(FRAC_DIGITS - int'(cnt_s1)));
		lim = neg_s1 ? VW'(HALF) : VW'(HALF - 1);
		over = neg_s1 ? (acc_s1 > ACC_W'(LIMQ_N)) : (acc_s1 > ACC_W'(LIMQ_P));
		raw = VW'(acc_s1) * VW'(PW) + VW'(frac_s1) * scale;
		mag = (over || raw > lim) ? lim : raw;
		present_n = present_q;
		g_n = g_q; m_n = m_q; t_n = t_q;
		if (fin_s1) begin
			present_n[slot_s1] = 1'b1;
			if (slot_s1 == gli_pkg::SL_G) g_n = code;
			if (slot_s1 == gli_pkg::SL_M) m_n = code;
			if (slot_s1 == gli_pkg::SL_T) t_n = code;
		end
	end

	assign wr_en = fin_s1 && (slot_s1 < gli_pkg::SL_G);
	assign wr_addr = slot_s1[gli_pkg::RAM_AW-1:0];
	assign wr_data = neg_s1 ? -$signed(mag) : $signed(mag);
	assign line = line_q;
	assign blocked = pend_q || line_s1 || line_q.valid;

endmodule

FILE: hw/rtl/gli_emitter.sv
// Line-end sequencer: walks the result list, reads stored values, updates modes.
module gli_emitter #(
	parameter int AXIS_COUNT  = 9,
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_DIGITS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gli_pkg::line_t                    line,
	output logic                              busy,
	output logic                              rd_en,
	output logic [gli_pkg::RAM_AW-1:0]        rd_addr,
	input  logic signed [VALUE_WIDTH-1:0]     rd_data,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [87:0]                       m_tdata,
	output logic [1:0]                        m_tuser,
	output logic                              m_tlast
);

	gli_pkg::emit_state_t state_q, state_n;
	logic [gli_pkg::IDX_W-1:0] idx_q;
	logic [gli_pkg::NSLOT-1:0] pres_q;
	logic signed [gli_pkg::CODE_W-1:0] g_q, m_q, tool_q;
	logic signed [VALUE_WIDTH-1:0] feed_q;
	logic metric_q, abs_q;
	logic [1:0] plane_q;
	logic valid_q, last_q;
	logic [87:0] data_q;
	logic [1:0] user_q;

	logic motion, arc, free, load;
	logic [gli_pkg::ITEM_COUNT-1:0] need, above;
	logic [8:0] mask;
	logic [3:0] kind, mkind, ei;
	logic [1:0] ek;
	logic [1:0] ctr;
	logic ccw;
	logic signed [31:0] arg, marg, ev;

	assign motion = pres_q[gli_pkg::SL_G] && g_q >= 16'sd0 && g_q <= 16'sd3;
	assign arc = motion && (g_q == 16'sd2 || g_q == 16'sd3);
	assign free = !valid_q || m_tready;
	assign ctr = 2'(idx_q - gli_pkg::IT_CTR);

	always_comb begin
		mask = '0;
		for (int i = 0; i < AXIS_COUNT; i++) mask[i] = pres_q[i];
		need = '0;
		need[0] = pres_q[gli_pkg::SL_G] && (motion || g_q == 16'sd4 || g_q == 16'sd28 ||
			g_q == 16'sd43 || (g_q >= 16'sd54 && g_q <= 16'sd59));
		for (int i = 0; i < AXIS_COUNT; i++) need[1 + i] = motion && pres_q[i];
		for (int i = 0; i < 3; i++) need[10 + i] = arc;
		need[13] = pres_q[gli_pkg::SL_M] && ((m_q >= 16'sd0 && m_q <= 16'sd9) || m_q == 16'sd30);
		above = need & ~((14'd2 << idx_q) - 14'd1);
	end

	// shared header fields of a motion line
	always_comb begin
		case (g_q)
			16'sd0: mkind = gli_pkg::CK_TRAVERSE;
			16'sd1: mkind = gli_pkg::CK_FEED;
			default: mkind = gli_pkg::CK_ARC;
		endcase
		marg = (g_q == 16'sd0) ? 32'sd0 : 32'(feed_q);
	end

	always_comb begin
		kind = '0; arg = '0; ccw = 1'b0; ek = gli_pkg::EK_HEADER; ei = '0; ev = '0;
		if (idx_q == gli_pkg::IT_HEAD) begin
			if (motion) begin
				kind = mkind; arg = marg; ccw = (g_q == 16'sd3);
			end else if (g_q == 16'sd4) begin
				kind = gli_pkg::CK_DWELL;
				arg = pres_q[gli_pkg::SL_P] ? 32'(rd_data) : 32'sd0;
			end else if (g_q == 16'sd43) begin
				kind = gli_pkg::CK_TOOLOFS;
			end else if (g_q == 16'sd28) begin
				kind = gli_pkg::CK_HOME;
			end else begin
				kind = gli_pkg::CK_COORD;
				arg = 32'(g_q - 16'sd54);
			end
		end else if (idx_q <= gli_pkg::IT_AX_LAST) begin
			kind = mkind; arg = marg; ccw = (g_q == 16'sd3);
			ek = gli_pkg::EK_AXIS; ei = idx_q - 4'd1; ev = 32'(rd_data);
		end else if (idx_q <= gli_pkg::IT_CTR_LAST) begin
			kind = mkind; arg = marg; ccw = (g_q == 16'sd3);
			ek = gli_pkg::EK_CENTRE; ei = 4'(ctr);
			ev = pres_q[gli_pkg::SL_I + 5'(ctr)] ? 32'(rd_data) : 32'sd0;
		end else begin
			case (m_q)
				16'sd0: kind = gli_pkg::CK_STOP;
				16'sd1: kind = gli_pkg::CK_OSTOP;
				16'sd3: begin kind = gli_pkg::CK_SPIN_ON; arg = 32'sd1; end
				16'sd4: begin kind = gli_pkg::CK_SPIN_ON; arg = -32'sd1; end
				16'sd5: kind = gli_pkg::CK_SPIN_OFF;
				16'sd6: begin kind = gli_pkg::CK_TOOLCHG; arg = 32'(tool_q); end
				16'sd7: kind = gli_pkg::CK_MIST_ON;
				16'sd8: kind = gli_pkg::CK_FLOOD;
				16'sd9: kind = gli_pkg::CK_MIST_OFF;
				default: kind = gli_pkg::CK_END;
			endcase
		end
	end

	always_comb begin
		state_n = state_q;
		rd_en = 1'b0;
		rd_addr = gli_pkg::SL_F[gli_pkg::RAM_AW-1:0];
		load = 1'b0;
		case (state_q)
			gli_pkg::E_IDLE: begin
				if (line.valid) begin
					rd_en = 1'b1;
					state_n = gli_pkg::E_FEED;
				end
			end
			gli_pkg::E_FEED: state_n = gli_pkg::E_SCAN;
			gli_pkg::E_SCAN: begin
				if (idx_q == gli_pkg::IT_END) begin
					state_n = gli_pkg::E_IDLE;
				end else if (need[idx_q]) begin
					rd_en = 1'b1;
					if (idx_q == gli_pkg::IT_HEAD) rd_addr = gli_pkg::SL_P[gli_pkg::RAM_AW-1:0];
					else if (idx_q <= gli_pkg::IT_AX_LAST) rd_addr = idx_q - 4'd1;
					else rd_addr = idx_q + 4'd2;
					state_n = gli_pkg::E_LOAD;
				end
			end
			gli_pkg::E_LOAD: begin
				if (free) begin
					load = 1'b1;
					state_n = gli_pkg::E_SCAN;
				end
			end
			default: state_n = gli_pkg::E_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gli_pkg::E_IDLE;
			idx_q <= '0;
			pres_q <= '0;
			feed_q <= VALUE_WIDTH'(300 * (10 ** FRAC_DIGITS));
			tool_q <= '0;
			metric_q <= 1'b1;
			abs_q <= 1'b1;
			plane_q <= gli_pkg::PL_XY;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == gli_pkg::E_IDLE && line.valid) begin
				pres_q <= line.present;
				idx_q <= '0;
				if (line.present[gli_pkg::SL_T]) tool_q <= line.t;
				if (line.present[gli_pkg::SL_G]) begin
					case (line.g)
						16'sd20: metric_q <= 1'b0;
						16'sd21: metric_q <= 1'b1;
						16'sd90: abs_q <= 1'b1;
						16'sd91: abs_q <= 1'b0;
						16'sd17, 16'sd18, 16'sd19: plane_q <= 2'(line.g - 16'sd17);
						default: ;
					endcase
				end
			end
			if (state_q == gli_pkg::E_FEED && pres_q[gli_pkg::SL_F]) feed_q <= rd_data;
			if (state_q == gli_pkg::E_SCAN && !need[idx_q] && idx_q != gli_pkg::IT_END)
				idx_q <= idx_q + 1'b1;
			if (load) idx_q <= idx_q + 1'b1;
			if (load) valid_q <= 1'b1;
			else if (m_tready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gli_pkg::E_IDLE && line.valid) begin
			g_q <= line.g;
			m_q <= line.m;
		end
		if (load) begin
			data_q <= {2'b00, plane_q, abs_q, metric_q, ev, ei, ccw, arg,
				(kind <= gli_pkg::CK_ARC || kind == gli_pkg::CK_HOME) ? mask : 9'd0, kind};
			user_q <= ek;
			last_q <= (above == '0);
		end
	end

	assign busy = (state_q != gli_pkg::E_IDLE);
	assign m_tvalid = valid_q;
	assign m_tdata = data_q;
	assign m_tuser = user_q;
	assign m_tlast = last_q;

endmodule

FILE: test/gcode_line_interpreter_test.sv
// Self-checking testbench for the G-code line interpreter: random text lines, line-end predictor.
module gcode_line_interpreter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NAXES = 9;
	localparam longint unsigned NUM_CAP = 64'd1 << 48;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 80;
	localparam int LONG_HOLD = 400;
	localparam int TOTAL_CHARS = 330;

	typedef struct {
		logic [7:0] ch;
		logic       line_end;
	} char_req_t;

	typedef struct {
		logic [3:0]  cmd_kind;
		logic [8:0]  axis_mask;
		logic [31:0] arg_value;
		logic        arc_ccw;
		logic [1:0]  elem_kind;
		logic [3:0]  elem_index;
		logic [31:0] elem_value;
		logic        metric_mode;
		logic        absolute_mode;
		logic [1:0]  plane_sel;
		logic        last;
	} gcmd_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	char_req_t char_q[$];
	gcmd_t     cmd_expect_q[$];
	int        errors;
	int        cmds_seen;

	gcode_line_interpreter u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// ---------------------------------------------------------------
	// Line interpreter shadow state
	// ---------------------------------------------------------------
	longint           wv[15];
	logic [31:0]      wpres;
	int               codes[3];
	longint unsigned  acc_int, acc_frac;
	int               frac_n;
	bit               neg, dot_seen, dot_stop, word_open;
	gli_pkg::phase_t  phase, cmt_return;
	logic [7:0]       letter;
	longint           feed_kept;
	int               tool_kept;
	bit               f_metric, f_abs;
	logic [1:0]       f_plane;

	// Map an upper-case letter to its word slot, -1 when ignored.
	function automatic int slot_of(logic [7:0] c);
		case (c)
			"X": return 0;
			"Y": return 1;
			"Z": return 2;
			"A": return 3;
			"B": return 4;
			"C": return 5;
			"U": return 6;
			"V": return 7;
			"W": return 8;
			"F": return gli_pkg::SL_F;
			"S": return gli_pkg::SL_S;
			"P": return gli_pkg::SL_P;
			"I": return gli_pkg::SL_I;
			"J": return gli_pkg::SL_J;
			"K": return gli_pkg::SL_K;
			"G": return gli_pkg::SL_G;
			"M": return gli_pkg::SL_M;
			"T": return gli_pkg::SL_T;
			default: return -1;
		endcase
	endfunction

	function automatic void clear_words();
		foreach (wv[i]) wv[i] = 0;
		wpres = '0;
		codes = '{0, 0, 0};
		acc_int = 0; acc_frac = 0; frac_n = 0;
		neg = 0; dot_seen = 0; dot_stop = 0; word_open = 0;
		phase = gli_pkg::PH_IDLE; cmt_return = gli_pkg::PH_IDLE; letter = '0;
	endfunction

	function automatic void reset_shadow();
		clear_words();
		feed_kept = 300 * 10000;
		tool_kept = 0;
		f_metric = 1; f_abs = 1; f_plane = gli_pkg::PL_XY;
	endfunction

	// Close the open word: code letters saturate to 16 bits, values to 32 bits scaled 1e4.
	function automatic void close_word();
		int              sl;
		longint unsigned lim, mag, scale;
		if (!word_open) return;
		word_open = 0;
		sl = slot_of(letter);
		if (sl < 0) return;
		wpres[sl] = 1'b1;
		if (sl >= gli_pkg::SL_G) begin
			if (neg) codes[sl - gli_pkg::SL_G] = (acc_int > 32768) ? -32768 : -int'(acc_int);
			else codes[sl - gli_pkg::SL_G] = (acc_int > 32767) ? 32767 : int'(acc_int);
			return;
		end
		lim = (64'd1 << 31) - (neg ? 0 : 1);
		scale = 1;
		for (int i = frac_n; i < 4; i++) scale *= 10;
		if (acc_int > lim / 10000) mag = lim;
		else begin
			mag = acc_int * 10000 + acc_frac * scale;
			if (mag > lim) mag = lim;
		end
		wv[sl] = neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic void scan_char(logic [7:0] c);
		bit digit;
		digit = (c >= "0" && c <= "9");
		if (phase == gli_pkg::PH_SKIP) return;
		if (phase == gli_pkg::PH_COMMENT) begin
			if (c == ")") phase = cmt_return;
			else if (c == ";" || c == 0) begin
				close_word();
				phase = gli_pkg::PH_SKIP;
			end
			return;
		end
		if (c == ";" || c == 0) begin
			close_word();
			phase = gli_pkg::PH_SKIP;
			return;
		end
		if (c == "(") begin
			cmt_return = phase;
			phase = gli_pkg::PH_COMMENT;
			return;
		end
		if (phase == gli_pkg::PH_LETTER && (c == "+" || c == "-")) begin
			neg = (c == "-");
			phase = gli_pkg::PH_NUMBER;
			return;
		end
		if ((phase == gli_pkg::PH_LETTER || phase == gli_pkg::PH_NUMBER) &&
			(digit || c == ".")) begin
			phase = gli_pkg::PH_NUMBER;
			if (dot_stop) return;
			if (c == ".") begin
				if (dot_seen) dot_stop = 1;
				else dot_seen = 1;
				return;
			end
			if (!dot_seen) begin
				acc_int = acc_int * 10 + (c - "0");
				if (acc_int > NUM_CAP) acc_int = NUM_CAP;
			end else if (frac_n < 4) begin
				acc_frac = acc_frac * 10 + (c - "0");
				frac_n++;
			end
			return;
		end
		close_word();
		phase = gli_pkg::PH_IDLE;
		if (c == " " || (c >= 9 && c <= 13)) return;
		letter = (c >= "a" && c <= "z") ? c - 8'd32 : c;
		acc_int = 0; acc_frac = 0; frac_n = 0;
		neg = 0; dot_seen = 0; dot_stop = 0;
		word_open = 1;
		phase = gli_pkg::PH_LETTER;
	endfunction

	function automatic void push_cmd(logic [3:0] kind, logic [8:0] mask, longint arg, bit ccw,
			logic [1:0] ek, logic [3:0] ei, longint ev);
		gcmd_t r;
		r.cmd_kind = kind; r.axis_mask = mask; r.arg_value = arg[31:0]; r.arc_ccw = ccw;
		r.elem_kind = ek; r.elem_index = ei; r.elem_value = ev[31:0];
		r.metric_mode = f_metric; r.absolute_mode = f_abs; r.plane_sel = f_plane;
		r.last = 0;
		cmd_expect_q.push_back(r);
	endfunction

	// Emit the canonical commands of a finished line and update the modes.
	function automatic void close_line();
		logic [8:0]  mask;
		int          n0, g;
		logic [3:0]  kind;
		longint      arg;
		logic [31:0] change_bits;
		change_bits = (32'd1 << gli_pkg::SL_G) | (32'd1 << gli_pkg::SL_M) |
			(32'd1 << gli_pkg::SL_F) | (32'd1 << gli_pkg::SL_S) | (32'd1 << gli_pkg::SL_T);
		mask = wpres[8:0];
		n0 = cmd_expect_q.size();
		if ((wpres & change_bits) == 0 && mask == 0) return;
		if (wpres[gli_pkg::SL_F]) feed_kept = wv[gli_pkg::SL_F];
		if (wpres[gli_pkg::SL_T]) tool_kept = codes[2];
		if (wpres[gli_pkg::SL_G]) begin
			g = codes[0];
			if (g >= 0 && g <= 3) begin
				kind = (g == 0) ? gli_pkg::CK_TRAVERSE :
					(g == 1 ? gli_pkg::CK_FEED : gli_pkg::CK_ARC);
				arg = (g == 0) ? 0 : feed_kept;
				push_cmd(kind, mask, arg, g == 3, gli_pkg::EK_HEADER, 4'd0, 0);
				for (int i = 0; i < NAXES; i++)
					if (mask[i]) push_cmd(kind, mask, arg, g == 3, gli_pkg::EK_AXIS, 4'(i), wv[i]);
				if (kind == gli_pkg::CK_ARC)
					for (int i = 0; i < 3; i++)
						push_cmd(kind, mask, arg, g == 3, gli_pkg::EK_CENTRE, 4'(i),
							wpres[gli_pkg::SL_I + i] ? wv[gli_pkg::SL_I + i] : 0);
			end else if (g == 4) push_cmd(gli_pkg::CK_DWELL, 0,
				wpres[gli_pkg::SL_P] ? wv[gli_pkg::SL_P] : 0, 0, gli_pkg::EK_HEADER, 4'd0, 0);
			else if (g >= 54 && g <= 59)
				push_cmd(gli_pkg::CK_COORD, 0, g - 54, 0, gli_pkg::EK_HEADER, 4'd0, 0);
			else if (g == 43) push_cmd(gli_pkg::CK_TOOLOFS, 0, 0, 0, gli_pkg::EK_HEADER, 4'd0, 0);
			else if (g == 28) push_cmd(gli_pkg::CK_HOME, mask, 0, 0, gli_pkg::EK_HEADER, 4'd0, 0);
			else if (g == 20) f_metric = 0;
			else if (g == 21) f_metric = 1;
			else if (g == 90) f_abs = 1;
			else if (g == 91) f_abs = 0;
			else if (g >= 17 && g <= 19) f_plane = 2'(g - 17);
		end
		if (wpres[gli_pkg::SL_M]) begin
			case (codes[1])
				0: push_cmd(gli_pkg::CK_STOP, 0, 0, 0, gli_pkg::EK_HEADER, 4'd0, 0);
				1: push_cmd(gli_pkg::CK_OSTOP, 0, 0, 0, gli_pkg::EK_HEADER, 4'd0, 0);
				2, 30: push_cmd(gli_pkg::CK_END, 0, 0, 0, gli_pkg::EK_HEADER, 4'd0, 0);
				3: push_cmd(gli_pkg::CK_SPIN_ON, 0, 1, 0, gli_pkg::EK_HEADER, 4'd0, 0);
				4: push_cmd(gli_pkg::CK_SPIN_ON, 0, -1, 0, gli_pkg::EK_HEADER, 4'd0, 0);
				5: push_cmd(gli_pkg::CK_SPIN_OFF, 0, 0, 0, gli_pkg::EK_HEADER, 4'd0, 0);
				6: push_cmd(gli_pkg::CK_TOOLCHG, 0, tool_kept, 0, gli_pkg::EK_HEADER, 4'd0, 0);
				7: push_cmd(gli_pkg::CK_MIST_ON, 0, 0, 0, gli_pkg::EK_HEADER, 4'd0, 0);
				9: push_cmd(gli_pkg::CK_MIST_OFF, 0, 0, 0, gli_pkg::EK_HEADER, 4'd0, 0);
				8: push_cmd(gli_pkg::CK_FLOOD, 0, 0, 0, gli_pkg::EK_HEADER, 4'd0, 0);
				default: ;
			endcase
		end
		if (cmd_expect_q.size() > n0) cmd_expect_q[$].last = 1;
	endfunction

	// ---------------------------------------------------------------
	// Text generation
	// ---------------------------------------------------------------
	function automatic string number_text(int max_int_digits);
		string s;
		int    nd;
		s = "";
		case ($urandom_range(0, 5))
			0: s = "-";
			1: s = "+";
			default: ;
		endcase
		nd = $urandom_range(0, max_int_digits);
		for (int i = 0; i < nd; i++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
		if ($urandom_range(0, 2) != 0) begin
			s = {s, "."};
			nd = $urandom_range(0, 6);
			for (int i = 0; i < nd; i++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
			if ($urandom_range(0, 9) == 0) s = $sformatf("%s.%0d", s, $urandom_range(0, 99));
		end
		return s;
	endfunction

	// Word separator: usually a space, sometimes nothing, a tab or a closed comment.
	function automatic string gap_text();
		case ($urandom_range(0, 9))
			0: return "";
			1: return "\t";
			2: return "(note)";
			default: return " ";
		endcase
	endfunction

	function automatic string word(string l, int digits);
		return {l, number_text(digits), gap_text()};
	endfunction

	function automatic string random_line();
		string s, axes;
		int    pick, k, codes_g[$], codes_m[$];
		axes = "XYZABCUVW";
		s = "";
		codes_g = '{4, 54, 55, 59, 43, 28, 20, 21, 90, 91, 17, 18, 19, 61, 64, 38, 80, 7, 10};
		codes_m = '{0, 1, 2, 30, 3, 4, 5, 6, 7, 8, 9, 48};
		pick = $urandom_range(0, 19);
		if (pick < 11) begin
			s = $sformatf("G%0d ", $urandom_range(0, 3));
			for (int i = 0; i < NAXES; i++)
				if ($urandom_range(0, 2) == 0) s = {s, word(axes.substr(i, i), 5)};
			if ($urandom_range(0, 1)) s = {s, word("I", 3)};
			if ($urandom_range(0, 1)) s = {s, word("J", 3)};
			if ($urandom_range(0, 1)) s = {s, word("K", 3)};
			if ($urandom_range(0, 2) == 0) s = {s, word("F", 4)};
		end else if (pick < 15) begin
			s = $sformatf("G%0d ", codes_g[$urandom_range(0, codes_g.size() - 1)]);
			if ($urandom_range(0, 1)) s = {s, word("P", 3)};
			if ($urandom_range(0, 1)) begin
				k = $urandom_range(0, 8);
				s = {s, word(axes.substr(k, k), 3)};
			end
		end else if (pick < 18) begin
			if ($urandom_range(0, 1)) s = {s, word("T", 2)};
			if ($urandom_range(0, 1)) s = {s, word("S", 4)};
			s = $sformatf("%sM%0d", s, codes_m[$urandom_range(0, codes_m.size() - 1)]);
		end else begin
			// noise: any byte value, including broken comments and control codes
			for (int i = $urandom_range(1, 10); i > 0; i--)
				s = $sformatf("%s%c", s, 8'($urandom_range(1, 255)));
			if ($urandom_range(0, 1)) s = {s, $sformatf("%c", 8'($urandom_range(0, 255)))};
		end
		if ($urandom_range(0, 7) == 0) s = s.tolower();
		if ($urandom_range(0, 9) == 0) s = {"N", number_text(3), " ", s, " ;tail X9"};
		return s;
	endfunction

	function automatic void queue_line(string s);
		char_req_t r;
		if (s.len() == 0) s = " ";
		for (int i = 0; i < s.len(); i++) begin
			r.ch = s[i];
			r.line_end = (i == s.len() - 1);
			char_q.push_back(r);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ---------------------------------------------------------------
	// Clock, reset and stimulus
	// ---------------------------------------------------------------
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		string directed[$];
		arst_n = 0;
		errors = 0;
		reset_shadow();
		directed = '{
			"G0 X0 Y0 Z0",
			"G1 X-999999.99999 Y214748.3647 Z99999999999 A+.5 F250.5",
			"G2 X1 Y1 I.5 J-.5 W-214748.3648",
			"G3 X1 K2 U3 V4 B5 C6",
			"g4 p1.5",
			"G54", "G59", "G43", "G28 X0 Z0",
			"G20", "G91", "G18", "G19", "G61",
			"G17 G90 G21 G64",
			"M0", "M1 M2", "M30", "S1000 M3", "M4",
			"T5 M6", "M7", "M9", "M8", "M5",
			"(comment) G1 X1 ; tail",
			"G1 X1(c)2.5 Y(open",
			"G1 X Y-. Z1.2.3",
			"N10 O5 D1 H2 Q3 R4 L5",
			"G38 X1", "G80", "G99999 M-99999", "T-9 M6", "F12.345678"
		};
		foreach (directed[i]) queue_line(directed[i]);
		while (char_q.size() < TOTAL_CHARS) queue_line(random_line());
		repeat (8) @(posedge clk);
		arst_n <= 1;
		while (char_q.size() != 0 || s_tvalid || cmd_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && cmd_expect_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// ---------------------------------------------------------------
	// Character driver: advance on every accepted request, feed the shadow parser
	// ---------------------------------------------------------------
	int        send_gap;
	char_req_t next_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				scan_char(s_tdata);
				if (s_tlast) begin
					close_word();
					close_line();
					clear_words();
				end
			end
			if (s_tvalid && !s_tready) begin
				// hold the pending request
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (char_q.size() != 0) begin
				next_req = char_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= next_req.ch;
				s_tlast <= next_req.line_end;
				send_gap = pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result monitor with random back-pressure and one long hold-off
	// ---------------------------------------------------------------
	int  recv_gap;
	int  hold_left;
	bit  hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap = 0;
			hold_left = 0;
			hold_done = 0;
		end else begin
			if (!hold_done && cmds_seen >= 15) begin
				hold_done = 1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_gap = pick_gap();
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		gcmd_t e;
		if (!arst_n) begin
			cmds_seen = 0;
		end else if (m_tvalid && m_tready) begin
			cmds_seen++;
			if (cmd_expect_q.size() == 0) begin
				$error("unexpected command: kind %0d", m_tdata[3:0]);
				errors++;
			end else begin
				e = cmd_expect_q.pop_front();
				if (m_tdata[3:0] !== e.cmd_kind) begin
					$error("cmd_kind: expected %0d, got %0d", e.cmd_kind, m_tdata[3:0]);
					errors++;
				end
				if (m_tdata[12:4] !== e.axis_mask) begin
					$error("axis_mask: expected %h, got %h", e.axis_mask, m_tdata[12:4]);
					errors++;
				end
				if (m_tdata[44:13] !== e.arg_value) begin
					$error("arg_value: expected %0d, got %0d",
						$signed(e.arg_value), $signed(m_tdata[44:13]));
					errors++;
				end
				if (m_tdata[45] !== e.arc_ccw) begin
					$error("arc_ccw: expected %0d, got %0d", e.arc_ccw, m_tdata[45]);
					errors++;
				end
				if (m_tuser !== e.elem_kind) begin
					$error("elem_kind: expected %0d, got %0d", e.elem_kind, m_tuser);
					errors++;
				end
				if (m_tdata[49:46] !== e.elem_index) begin
					$error("elem_index: expected %0d, got %0d", e.elem_index, m_tdata[49:46]);
					errors++;
				end
				if (m_tdata[81:50] !== e.elem_value) begin
					$error("elem_value: expected %0d, got %0d",
						$signed(e.elem_value), $signed(m_tdata[81:50]));
					errors++;
				end
				if (m_tdata[82] !== e.metric_mode) begin
					$error("metric_mode: expected %0d, got %0d", e.metric_mode, m_tdata[82]);
					errors++;
				end
				if (m_tdata[83] !== e.absolute_mode) begin
					$error("absolute_mode: expected %0d, got %0d", e.absolute_mode, m_tdata[83]);
					errors++;
				end
				if (m_tdata[85:84] !== e.plane_sel) begin
					$error("plane_sel: expected %0d, got %0d", e.plane_sel, m_tdata[85:84]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Watchdog: cycles with no accepted request on either side
	// ---------------------------------------------------------------
	int idle_cycles;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

endmodule
